// ===== rtl/hppr_pkg.sv =====
// Package: shared types and constants of the HTTP payload pattern replacer.
package hppr_pkg;

  localparam int CFG_W     = 64;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PATTERN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LENGTH       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_PATTERN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH  = 2'd3;

  // Reset values: "curl/" and "Mozilla/", byte 0 in the low bits
  localparam logic [CFG_W-1:0] TARGET_PATTERN_RST      = 64'h0000_002F_6C72_7563;
  localparam logic [LEN_W-1:0] TARGET_LENGTH_RST       = 4'd5;
  localparam logic [CFG_W-1:0] REPLACEMENT_PATTERN_RST = 64'h2F61_6C6C_697A_6F4D;
  localparam logic [LEN_W-1:0] REPLACEMENT_LENGTH_RST  = 4'd8;

  localparam logic [LEN_W-1:0] MIN_TARGET_LEN  = 4'd4;
  localparam logic [LEN_W-1:0] MIN_REPLACE_LEN = 4'd1;

  // Byte position counter saturates here; the method is decided on that byte
  localparam logic [2:0] POS_SAT = 3'd4;

  // Method prefixes
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_T = 8'h54;

  typedef enum logic [1:0] {
    METH_UNDECIDED = 2'd0,
    METH_REWRITE   = 2'd1,
    METH_PASS      = 2'd2
  } meth_t;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_REPL,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic take;        // accept the input beat this cycle
    logic repl_step;   // load the next replacement byte
    logic flush_step;  // load the oldest window byte
  } cmd_t;

  typedef struct packed {
    logic slot_free;   // output register can take a beat
    logic match;       // beat on the input completes a pattern match
    logic last;        // beat on the input ends its payload
    logic repl_last;   // current replacement byte is the final one
    logic flush_last;  // one byte left in the window
  } status_t;

endpackage

// ===== rtl/hppr_in_if.sv =====
// Interface: payload byte input channel.
interface hppr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_payload;
  logic       packet_ok;

  modport source (output valid, data_byte, end_of_payload, packet_ok, input ready);
  modport sink   (input valid, data_byte, end_of_payload, packet_ok, output ready);
endinterface

// ===== rtl/hppr_out_if.sv =====
// Interface: rewritten byte output channel.
interface hppr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_end;
  logic       replaced_flag;

  modport source (output valid, out_byte, out_end, replaced_flag, input ready);
  modport sink   (input valid, out_byte, out_end, replaced_flag, output ready);
endinterface

// ===== rtl/hppr_dp.sv =====
// Datapath: lookahead window, method detection, pattern compare and output register.
module hppr_dp #(
  parameter int MAX_PATTERN_BYTES = 8,
  parameter int MAX_REPLACE_BYTES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hppr_pkg::cmd_t              cmd,
  output hppr_pkg::status_t           st,
  input  logic [7:0]                  data_byte,
  input  logic                        end_of_payload,
  input  logic                        packet_ok,
  input  logic [hppr_pkg::CFG_W-1:0]  target_pattern,
  input  logic [hppr_pkg::LEN_W-1:0]  target_length,
  input  logic [hppr_pkg::CFG_W-1:0]  replacement_pattern,
  input  logic [hppr_pkg::LEN_W-1:0]  replacement_length,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [7:0]                  out_byte,
  output logic                        out_end,
  output logic                        replaced_flag
);

  localparam int FW = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int KW = (MAX_REPLACE_BYTES > 1) ? $clog2(MAX_REPLACE_BYTES) : 1;

  logic [7:0]          window_r   [MAX_PATTERN_BYTES];
  logic [7:0]          window_nxt [MAX_PATTERN_BYTES];
  logic [7:0]          window_app [MAX_PATTERN_BYTES];
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [2:0]          pos_r, pos_nxt;
  hppr_pkg::meth_t     meth_r, meth_nxt;
  logic                done_r, done_nxt;
  logic [FW-1:0]       tlen_r, tlen_nxt;
  logic                last_r, last_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_end_r, out_end_nxt;
  logic                out_flag_r, out_flag_nxt;

  logic                    first;
  logic [hppr_pkg::LEN_W-1:0] tlen_cl, rlen_cl;
  logic [FW-1:0]           tlen_eff, fill_eff, fill_app;
  logic [2:0]              pos_new;
  hppr_pkg::meth_t         meth_eff, meth_new;
  logic                    done_eff, method_hit, pat_eq, full, match;
  logic [7:0]              repl_byte;
  logic                    load;

  always_comb begin
    first = (pos_r == 3'd0);

    if (target_length < hppr_pkg::MIN_TARGET_LEN) begin
      tlen_cl = hppr_pkg::MIN_TARGET_LEN;
    end else if (target_length > hppr_pkg::LEN_W'(MAX_PATTERN_BYTES)) begin
      tlen_cl = hppr_pkg::LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      tlen_cl = target_length;
    end
    if (replacement_length < hppr_pkg::MIN_REPLACE_LEN) begin
      rlen_cl = hppr_pkg::MIN_REPLACE_LEN;
    end else if (replacement_length > hppr_pkg::LEN_W'(MAX_REPLACE_BYTES)) begin
      rlen_cl = hppr_pkg::LEN_W'(MAX_REPLACE_BYTES);
    end else begin
      rlen_cl = replacement_length;
    end

    // A payload's first byte restarts the per-payload state
    tlen_eff = first ? FW'(tlen_cl) : tlen_r;
    fill_eff = first ? '0 : fill_r;
    meth_eff = first ? (packet_ok ? hppr_pkg::METH_UNDECIDED : hppr_pkg::METH_PASS) : meth_r;
    done_eff = first ? 1'b0 : done_r;

    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      window_app[i] = (FW'(i) == fill_eff) ? data_byte : window_r[i];
    end
    fill_app = fill_eff + FW'(1);
    pos_new  = (pos_r < hppr_pkg::POS_SAT) ? pos_r + 3'd1 : pos_r;

    method_hit =
      (window_app[0] == hppr_pkg::CH_G && window_app[1] == hppr_pkg::CH_E &&
       window_app[2] == hppr_pkg::CH_T) ||
      (window_app[0] == hppr_pkg::CH_P && window_app[1] == hppr_pkg::CH_O &&
       window_app[2] == hppr_pkg::CH_S && window_app[3] == hppr_pkg::CH_T) ||
      (window_app[0] == hppr_pkg::CH_H && window_app[1] == hppr_pkg::CH_E &&
       window_app[2] == hppr_pkg::CH_A && window_app[3] == hppr_pkg::CH_D);

    if (meth_eff == hppr_pkg::METH_UNDECIDED && pos_new == hppr_pkg::POS_SAT) begin
      meth_new = method_hit ? hppr_pkg::METH_REWRITE : hppr_pkg::METH_PASS;
    end else begin
      meth_new = meth_eff;
    end

    pat_eq = 1'b1;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (FW'(i) < tlen_eff && window_app[i] != target_pattern[8*i +: 8]) begin
        pat_eq = 1'b0;
      end
    end
    full  = (fill_app == tlen_eff);
    match = (meth_new == hppr_pkg::METH_REWRITE) && !done_eff && full && pat_eq;

    repl_byte = replacement_pattern[7:0];
    for (int i = 0; i < MAX_REPLACE_BYTES; i++) begin
      if (k_r == KW'(i)) begin
        repl_byte = replacement_pattern[8*i +: 8];
      end
    end

    st.slot_free  = !out_valid_r || out_ready;
    st.match      = match;
    st.last       = end_of_payload;
    st.repl_last  = (k_r == KW'(rlen_cl - hppr_pkg::LEN_W'(1)));
    st.flush_last = (fill_r == FW'(1));
  end

  always_comb begin
    window_nxt   = window_r;
    fill_nxt     = fill_r;
    pos_nxt      = pos_r;
    meth_nxt     = meth_r;
    done_nxt     = done_r;
    tlen_nxt     = tlen_r;
    last_nxt     = last_r;
    k_nxt        = k_r;
    out_byte_nxt = out_byte_r;
    out_end_nxt  = out_end_r;
    out_flag_nxt = out_flag_r;
    load         = 1'b0;

    if (cmd.take) begin
      window_nxt = window_app;
      fill_nxt   = fill_app;
      pos_nxt    = end_of_payload ? 3'd0 : pos_new;
      meth_nxt   = meth_new;
      done_nxt   = done_eff;
      tlen_nxt   = tlen_eff;
      last_nxt   = end_of_payload;
      if (match) begin
        // drop the matched window, replacement bytes follow
        fill_nxt = '0;
        done_nxt = 1'b1;
        k_nxt    = '0;
      end else if (!end_of_payload && full) begin
        // window full: emit its oldest byte right away
        load         = 1'b1;
        out_byte_nxt = window_app[0];
        out_end_nxt  = 1'b0;
        out_flag_nxt = 1'b0;
        for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
          window_nxt[i] = window_app[i+1];
        end
        fill_nxt = fill_app - FW'(1);
      end
    end else if (cmd.repl_step) begin
      load         = 1'b1;
      out_byte_nxt = repl_byte;
      out_end_nxt  = last_r && st.repl_last;
      out_flag_nxt = last_r && st.repl_last;
      k_nxt        = k_r + KW'(1);
    end else if (cmd.flush_step) begin
      load         = 1'b1;
      out_byte_nxt = window_r[0];
      out_end_nxt  = st.flush_last;
      out_flag_nxt = st.flush_last && done_r;
      for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
        window_nxt[i] = window_r[i+1];
      end
      fill_nxt = fill_r - FW'(1);
    end

    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pos_r       <= '0;
      meth_r      <= hppr_pkg::METH_UNDECIDED;
      done_r      <= 1'b0;
      tlen_r      <= FW'(hppr_pkg::TARGET_LENGTH_RST);
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      meth_r      <= meth_nxt;
      done_r      <= done_nxt;
      tlen_r      <= tlen_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    window_r   <= window_nxt;
    k_r        <= k_nxt;
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_end       = out_end_r;
  assign replaced_flag = out_flag_r;

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_step |-> fill_r != '0)
    else $error("flush step with an empty window");

  a_flag_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_end_r) |-> !out_flag_r)
    else $error("replaced flag on a beat that does not end the payload");

  a_match_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && match) |=> (done_r && fill_r == '0))
    else $error("match did not clear the window and mark the replacement");

endmodule

// ===== rtl/hppr_ctrl.sv =====
// Controller: sequences accept, replacement burst and end-of-payload flush.
module hppr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hppr_pkg::status_t st,
  output hppr_pkg::cmd_t    cmd
);

  hppr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hppr_pkg::ST_ACCEPT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd.take       = 1'b0;
    cmd.repl_step  = 1'b0;
    cmd.flush_step = 1'b0;
    case (state_r)
      hppr_pkg::ST_ACCEPT: begin
        in_ready = st.slot_free;
        cmd.take = in_valid && st.slot_free;
        if (cmd.take) begin
          if (st.match) begin
            state_nxt = hppr_pkg::ST_REPL;
          end else if (st.last) begin
            state_nxt = hppr_pkg::ST_FLUSH;
          end
        end
      end
      hppr_pkg::ST_REPL: begin
        cmd.repl_step = st.slot_free;
        if (st.slot_free && st.repl_last) begin
          state_nxt = hppr_pkg::ST_ACCEPT;
        end
      end
      hppr_pkg::ST_FLUSH: begin
        cmd.flush_step = st.slot_free;
        if (st.slot_free && st.flush_last) begin
          state_nxt = hppr_pkg::ST_ACCEPT;
        end
      end
      default: begin
        state_nxt = hppr_pkg::ST_ACCEPT;
      end
    endcase
  end

  a_match_to_repl: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && st.match) |=> state_r == hppr_pkg::ST_REPL)
    else $error("match did not start the replacement burst");

  a_flush_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hppr_pkg::ST_FLUSH && st.slot_free && st.flush_last)
      |=> state_r == hppr_pkg::ST_ACCEPT)
    else $error("flush did not return to accept after the final byte");

endmodule

// ===== rtl/http_payload_pattern_replace.sv =====
// Top level: HTTP payload find-and-replace with configuration registers.
//
//  channel   dir  handshake        payload
//  in_chan   in   valid/ready      data_byte, end_of_payload, packet_ok
//  out_chan  out  valid/ready      out_byte, out_end, replaced_flag
//  cfg_*     in   cfg_we only      cfg_index, cfg_data
//
// One input byte per cycle while no burst is running; the oldest window byte
// leaves through the output register in the same cycle the new byte enters.
// A match holds the input off during the replacement burst; a payload end
// holds it while the window's bytes, up to the pattern length, go out.
// The controller runs both bursts, one byte a cycle unless stalled.
// Reset (rst_n low, synchronous) restores the default pattern "curl/" and
// replacement "Mozilla/" and empties the output register; no clearing pass.
// A stalled output register holds the input off; all output comes from it.
module http_payload_pattern_replace #(
  parameter int MAX_PATTERN_BYTES = 8,
  parameter int MAX_REPLACE_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hppr_in_if.sink                        in_chan,
  hppr_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [hppr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hppr_pkg::CFG_W-1:0]     cfg_data
);

  logic [hppr_pkg::CFG_W-1:0] target_pattern_r, target_pattern_nxt;
  logic [hppr_pkg::LEN_W-1:0] target_length_r, target_length_nxt;
  logic [hppr_pkg::CFG_W-1:0] replacement_pattern_r, replacement_pattern_nxt;
  logic [hppr_pkg::LEN_W-1:0] replacement_length_r, replacement_length_nxt;

  hppr_pkg::cmd_t    cmd;
  hppr_pkg::status_t st;

  // Register file: lengths keep the low nibble, patterns the full word
  always_comb begin
    target_pattern_nxt      = target_pattern_r;
    target_length_nxt       = target_length_r;
    replacement_pattern_nxt = replacement_pattern_r;
    replacement_length_nxt  = replacement_length_r;
    if (cfg_we) begin
      case (cfg_index)
        hppr_pkg::CFG_TARGET_PATTERN:      target_pattern_nxt      = cfg_data;
        hppr_pkg::CFG_TARGET_LENGTH:       target_length_nxt       =
                                             cfg_data[hppr_pkg::LEN_W-1:0];
        hppr_pkg::CFG_REPLACEMENT_PATTERN: replacement_pattern_nxt = cfg_data;
        hppr_pkg::CFG_REPLACEMENT_LENGTH:  replacement_length_nxt  =
                                             cfg_data[hppr_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_pattern_r      <= hppr_pkg::TARGET_PATTERN_RST;
      target_length_r       <= hppr_pkg::TARGET_LENGTH_RST;
      replacement_pattern_r <= hppr_pkg::REPLACEMENT_PATTERN_RST;
      replacement_length_r  <= hppr_pkg::REPLACEMENT_LENGTH_RST;
    end else begin
      target_pattern_r      <= target_pattern_nxt;
      target_length_r       <= target_length_nxt;
      replacement_pattern_r <= replacement_pattern_nxt;
      replacement_length_r  <= replacement_length_nxt;
    end
  end

  // Controller: decides which beat moves each cycle
  hppr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: window, compare and output register
  hppr_dp #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .MAX_REPLACE_BYTES (MAX_REPLACE_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .data_byte           (in_chan.data_byte),
    .end_of_payload      (in_chan.end_of_payload),
    .packet_ok           (in_chan.packet_ok),
    .target_pattern      (target_pattern_r),
    .target_length       (target_length_r),
    .replacement_pattern (replacement_pattern_r),
    .replacement_length  (replacement_length_r),
    .out_ready           (out_chan.ready),
    .out_valid           (out_chan.valid),
    .out_byte            (out_chan.out_byte),
    .out_end             (out_chan.out_end),
    .replaced_flag       (out_chan.replaced_flag)
  );

endmodule

// ===== bench/testbench.sv =====
// Testbench: directed and random payload streams against a beat-level rewrite predictor.
module testbench;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 24;      // longest burst (8 bytes) plus pipeline, with margin
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BEATS = 380;
  localparam int MAX_REPORTS  = 10;
  localparam int WINDOW_BYTES = 8;
  localparam int REPL_BYTES   = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic       ok;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic       replaced;
  } out_beat_t;

  typedef enum int {
    PFX_GET,
    PFX_POST,
    PFX_HEAD
  } method_pfx_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [hppr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hppr_pkg::CFG_W-1:0]     cfg_data;

  hppr_in_if  in_chan();
  hppr_out_if out_chan();

  http_payload_pattern_replace DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Shadow copy of the configuration registers
  logic [hppr_pkg::CFG_W-1:0] shadow_target;
  logic [hppr_pkg::CFG_W-1:0] shadow_replacement;
  logic [hppr_pkg::LEN_W-1:0] shadow_tlen;
  logic [hppr_pkg::LEN_W-1:0] shadow_rlen;

  // Rewrite state of the payload in flight
  logic [7:0]      window_q [WINDOW_BYTES];
  int unsigned     window_fill;
  int unsigned     payload_tlen;
  logic [2:0]      byte_pos;
  hppr_pkg::meth_t req_method;
  logic            swap_done;

  out_beat_t expected_q[$];   // rewritten beats still owed by the block
  out_beat_t step_beats[$];   // beats produced by one input beat
  in_beat_t  pending_q[$];    // input beats not yet offered
  logic [7:0] draft[$];       // payload under construction

  int unsigned queued_beats;
  int unsigned mismatch_count;
  logic [31:0] cycle_count;

  function automatic int unsigned clamp_len(logic [hppr_pkg::LEN_W-1:0] v, int unsigned lo,
                                            int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic void emit_beat(logic [7:0] d);
    out_beat_t ob;
    ob.data     = d;
    ob.eop      = 1'b0;
    ob.replaced = 1'b0;
    step_beats.push_back(ob);
  endfunction

  // Drop the oldest window byte onto the output and shift the window down
  function automatic void emit_oldest();
    emit_beat(window_q[0]);
    for (int i = 0; i < WINDOW_BYTES - 1; i++) window_q[i] = window_q[i + 1];
    window_fill--;
  endfunction

  // Advance the rewrite state by one accepted input beat and queue what it releases
  function automatic void rewrite_beat(in_beat_t b);
    logic      hit;
    out_beat_t tail;
    step_beats.delete();
    // First byte of a payload: latch the pattern length and the rewrite permission
    if (byte_pos == 0) begin
      payload_tlen = clamp_len(shadow_tlen, hppr_pkg::MIN_TARGET_LEN, WINDOW_BYTES);
      req_method   = b.ok ? hppr_pkg::METH_UNDECIDED : hppr_pkg::METH_PASS;
      swap_done    = 1'b0;
      window_fill  = 0;
    end
    if (window_fill >= payload_tlen) emit_oldest();
    window_q[window_fill] = b.data;
    window_fill++;
    if (byte_pos < hppr_pkg::POS_SAT) byte_pos++;
    // Decide the method once four bytes are in
    if (req_method == hppr_pkg::METH_UNDECIDED && byte_pos == hppr_pkg::POS_SAT) begin
      if ((window_q[0] == hppr_pkg::CH_G && window_q[1] == hppr_pkg::CH_E &&
           window_q[2] == hppr_pkg::CH_T) ||
          (window_q[0] == hppr_pkg::CH_P && window_q[1] == hppr_pkg::CH_O &&
           window_q[2] == hppr_pkg::CH_S && window_q[3] == hppr_pkg::CH_T) ||
          (window_q[0] == hppr_pkg::CH_H && window_q[1] == hppr_pkg::CH_E &&
           window_q[2] == hppr_pkg::CH_A && window_q[3] == hppr_pkg::CH_D)) begin
        req_method = hppr_pkg::METH_REWRITE;
      end else begin
        req_method = hppr_pkg::METH_PASS;
      end
    end
    // Full window against the live pattern; only the first hit is replaced
    if (req_method == hppr_pkg::METH_REWRITE && !swap_done &&
        window_fill == payload_tlen) begin
      hit = 1'b1;
      for (int k = 0; k < payload_tlen; k++)
        if (window_q[k] != shadow_target[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        for (int k = 0; k < clamp_len(shadow_rlen, hppr_pkg::MIN_REPLACE_LEN, REPL_BYTES);
             k++)
          emit_beat(shadow_replacement[8*k +: 8]);
        window_fill = 0;
        swap_done   = 1'b1;
      end
    end
    if (b.eop) begin
      // Flush the window; the final beat carries the end mark and the replace flag
      while (window_fill > 0) emit_oldest();
      if (step_beats.size() > 0) begin
        tail          = step_beats.pop_back();
        tail.eop      = 1'b1;
        tail.replaced = swap_done;
        step_beats.push_back(tail);
      end
      byte_pos    = '0;
      req_method  = hppr_pkg::METH_UNDECIDED;
      swap_done   = 1'b0;
      window_fill = 0;
    end else if (window_fill == payload_tlen) begin
      emit_oldest();
    end
    foreach (step_beats[i]) expected_q.push_back(step_beats[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Payload construction
  // ---------------------------------------------------------------------------

  function automatic void add_noise(int unsigned n);
    repeat (n) draft.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_method(method_pfx_t m);
    case (m)
      PFX_GET: begin
        draft.push_back(hppr_pkg::CH_G); draft.push_back(hppr_pkg::CH_E);
        draft.push_back(hppr_pkg::CH_T);
      end
      PFX_POST: begin
        draft.push_back(hppr_pkg::CH_P); draft.push_back(hppr_pkg::CH_O);
        draft.push_back(hppr_pkg::CH_S); draft.push_back(hppr_pkg::CH_T);
      end
      default: begin
        draft.push_back(hppr_pkg::CH_H); draft.push_back(hppr_pkg::CH_E);
        draft.push_back(hppr_pkg::CH_A); draft.push_back(hppr_pkg::CH_D);
      end
    endcase
  endfunction

  // Append the first n bytes of the current target pattern
  function automatic void add_target(int unsigned n);
    for (int k = 0; k < n; k++) draft.push_back(shadow_target[8*k +: 8]);
  endfunction

  // Move the draft into the pending queue; packet_ok only counts on a payload's first beat,
  // so randomize it everywhere else
  function automatic void commit_payload(logic ok, logic close);
    in_beat_t item;
    foreach (draft[i]) begin
      item.data = draft[i];
      item.eop  = close && (i == draft.size() - 1);
      item.ok   = (i == 0) ? ok : 1'($urandom_range(0, 1));
      pending_q.push_back(item);
      queued_beats++;
    end
    draft.delete();
  endfunction

  function automatic void build_random_payload();
    int unsigned tl;
    int unsigned kind;
    int unsigned j;
    tl   = clamp_len(shadow_tlen, hppr_pkg::MIN_TARGET_LEN, WINDOW_BYTES);
    kind = $urandom_range(0, 19);
    if (kind <= 10) begin
      // Well-formed request: method, filler, pattern (sometimes partial), filler, sometimes the pattern again;
      // an empty trailing filler lands the hit on the last byte
      add_method(method_pfx_t'($urandom_range(0, 2)));
      add_noise($urandom_range(0, 5));
      if ($urandom_range(0, 3) == 0) add_target($urandom_range(1, tl - 1));
      else add_target(tl);
      add_noise($urandom_range(0, 5));
      if ($urandom_range(0, 3) == 0) add_target(tl);
      commit_payload(1'b1, 1'b1);
    end else if (kind <= 12) begin
      // Pattern from the very first byte; rewrites only when it is method-led
      add_target(tl);
      add_noise($urandom_range(0, 4));
      commit_payload(1'b1, 1'b1);
    end else if (kind == 13) begin
      // Not allowed to rewrite
      add_method(method_pfx_t'($urandom_range(0, 2)));
      add_target(tl);
      add_noise($urandom_range(0, 3));
      commit_payload(1'b0, 1'b1);
    end else if (kind == 14) begin
      // Short payload, ends before the method is decided
      add_method(method_pfx_t'($urandom_range(0, 2)));
      j = $urandom_range(1, 3);
      while (draft.size() > j) void'(draft.pop_back());
      commit_payload(1'($urandom_range(0, 1)), 1'b1);
    end else if (kind <= 16) begin
      // Method with one corrupted character
      add_method(method_pfx_t'($urandom_range(0, 2)));
      j = $urandom_range(0, draft.size() - 1);
      draft[j] = draft[j] ^ 8'($urandom_range(1, 255));
      add_target(tl);
      add_noise($urandom_range(0, 4));
      commit_payload(1'b1, 1'b1);
    end else begin
      add_noise($urandom_range(1, 16));
      commit_payload(1'($urandom_range(0, 1)), 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration and phase control
  // ---------------------------------------------------------------------------

  // Hold until every beat is offered and every owed beat is out, then let bursts die down
  task automatic settle();
    @(negedge clk);
    while (pending_q.size() != 0 || in_chan.valid || expected_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [hppr_pkg::CFG_IDX_W-1:0] idx,
                           logic [hppr_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      hppr_pkg::CFG_TARGET_PATTERN:      shadow_target      = value;
      hppr_pkg::CFG_TARGET_LENGTH:       shadow_tlen        = value[hppr_pkg::LEN_W-1:0];
      hppr_pkg::CFG_REPLACEMENT_PATTERN: shadow_replacement = value;
      default:                           shadow_rlen        = value[hppr_pkg::LEN_W-1:0];
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Length values: below range, both range ends, above range, or anything
  function automatic logic [hppr_pkg::CFG_W-1:0] pick_len(int unsigned lo);
    logic [hppr_pkg::CFG_W-1:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) v[hppr_pkg::CFG_W-1:hppr_pkg::LEN_W] = '0;
    case ($urandom_range(0, 4))
      0:       v[hppr_pkg::LEN_W-1:0] = '0;
      1:       v[hppr_pkg::LEN_W-1:0] = hppr_pkg::LEN_W'(lo);
      2:       v[hppr_pkg::LEN_W-1:0] = hppr_pkg::LEN_W'(WINDOW_BYTES);
      3:       v[hppr_pkg::LEN_W-1:0] = '1;
      default: v[hppr_pkg::LEN_W-1:0] = hppr_pkg::LEN_W'($urandom_range(0, 15));
    endcase
    return v;
  endfunction

  task automatic pick_settings(logic [3:0] mask);
    logic [hppr_pkg::CFG_W-1:0] p;
    if (mask[0]) begin
      case ($urandom_range(0, 5))
        0: p = '0;
        1: p = '1;
        2: p = {$urandom, $urandom};
        default: begin
          for (int k = 0; k < 8; k++) p[8*k +: 8] = 8'($urandom_range(32, 126));
          // Often lead with a method so the pattern can sit at offset zero
          case ($urandom_range(0, 3))
            0: p[23:0] = {hppr_pkg::CH_T, hppr_pkg::CH_E, hppr_pkg::CH_G};
            1: p[31:0] = {hppr_pkg::CH_T, hppr_pkg::CH_S, hppr_pkg::CH_O, hppr_pkg::CH_P};
            2: p[31:0] = {hppr_pkg::CH_D, hppr_pkg::CH_A, hppr_pkg::CH_E, hppr_pkg::CH_H};
            default: ;
          endcase
        end
      endcase
      write_reg(hppr_pkg::CFG_TARGET_PATTERN, p);
    end
    if (mask[1]) write_reg(hppr_pkg::CFG_TARGET_LENGTH, pick_len(hppr_pkg::MIN_TARGET_LEN));
    if (mask[2]) write_reg(hppr_pkg::CFG_REPLACEMENT_PATTERN, {$urandom, $urandom});
    if (mask[3]) write_reg(hppr_pkg::CFG_REPLACEMENT_LENGTH,
                           pick_len(hppr_pkg::MIN_REPLACE_LEN));
    end_writes();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps, and stretches of back-to-back beats
  // ---------------------------------------------------------------------------

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned burst_count;

  always @(posedge clk) begin : driver
    in_beat_t nxt;
    in_beat_t seen;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      burst_left  = 1;
      gap_left    = 0;
      burst_count = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        seen.data = in_chan.data_byte;
        seen.eop  = in_chan.end_of_payload;
        seen.ok   = in_chan.packet_ok;
        rewrite_beat(seen);
      end
      // Hold a beat that was not taken; otherwise advance
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          in_chan.valid          <= 1'b1;
          in_chan.data_byte      <= nxt.data;
          in_chan.end_of_payload <= nxt.eop;
          in_chan.packet_ok      <= nxt.ok;
          burst_left--;
          if (burst_left == 0) begin
            burst_count++;
            burst_left = $urandom_range(1, 24);
            gap_left   = (burst_count % 16 < 4) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each output beat against the oldest owed beat; stall on a pattern
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    out_beat_t got;
    out_beat_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end else if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.data     = out_chan.out_byte;
        got.eop      = out_chan.out_end;
        got.replaced = out_chan.replaced_flag;
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected beat: byte %h end %b replaced %b",
                     got.data, got.eop, got.replaced);
        end else begin
          want = expected_q.pop_front();
          if (got.data !== want.data || got.eop !== want.eop ||
              got.replaced !== want.replaced) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"mismatch: expected byte %h end %b replaced %b, ",
                        "got byte %h end %b replaced %b"},
                       want.data, want.eop, want.replaced,
                       got.data, got.eop, got.replaced);
          end
        end
      end
      // Stall modes rotate with the cycle count: always ready, random, periodic, long stalls
      case (cycle_count[10:9])
        2'd0:    out_chan.ready <= 1'b1;
        2'd1:    out_chan.ready <= ($urandom_range(0, 9) < 7);
        2'd2:    out_chan.ready <= (cycle_count % 5 >= 2);
        default: out_chan.ready <= (cycle_count[6:4] != 3'b101);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned      random_beats;
    int unsigned      phase_start;
    int unsigned      phase_len;
    logic             first_phase;
    logic             open_tail;
    logic [31:0]      tail_bytes;

    clk       = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_chan.valid          = 1'b0;
    in_chan.data_byte      = '0;
    in_chan.end_of_payload = 1'b0;
    in_chan.packet_ok      = 1'b0;
    out_chan.ready         = 1'b0;
    cycle_count    = '0;
    mismatch_count = 0;
    queued_beats   = 0;

    shadow_target      = hppr_pkg::TARGET_PATTERN_RST;
    shadow_tlen        = hppr_pkg::TARGET_LENGTH_RST;
    shadow_replacement = hppr_pkg::REPLACEMENT_PATTERN_RST;
    shadow_rlen        = hppr_pkg::REPLACEMENT_LENGTH_RST;
    for (int i = 0; i < WINDOW_BYTES; i++) window_q[i] = '0;
    window_fill  = 0;
    payload_tlen = hppr_pkg::TARGET_LENGTH_RST;
    byte_pos     = '0;
    req_method   = hppr_pkg::METH_UNDECIDED;
    swap_done    = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset strings: "GET" then the pattern, hit ending on the payload's last byte
    add_method(PFX_GET);
    add_target(hppr_pkg::TARGET_LENGTH_RST);
    commit_payload(1'b1, 1'b1);
    // Two-byte "GE": too short to rewrite
    add_method(PFX_GET);
    void'(draft.pop_back());
    commit_payload(1'b1, 1'b1);
    // Byte extremes, rewrite not allowed
    draft.push_back(8'h00);
    draft.push_back(8'hFF);
    commit_payload(1'b0, 1'b1);
    settle();

    // Lengths below range clamp to 4 and 1; pattern "POST" hits at offset zero
    write_reg(hppr_pkg::CFG_TARGET_PATTERN,
              {32'h0, hppr_pkg::CH_T, hppr_pkg::CH_S, hppr_pkg::CH_O, hppr_pkg::CH_P});
    write_reg(hppr_pkg::CFG_TARGET_LENGTH, '0);
    write_reg(hppr_pkg::CFG_REPLACEMENT_PATTERN, '1);
    write_reg(hppr_pkg::CFG_REPLACEMENT_LENGTH, '0);
    end_writes();
    add_method(PFX_POST);
    add_noise(1);
    commit_payload(1'b1, 1'b1);
    settle();

    // Lengths above range clamp to 8; then change settings in the middle of a payload:
    // the new target length must wait for the next payload, the pattern applies at once
    write_reg(hppr_pkg::CFG_TARGET_LENGTH, 64'd15);
    write_reg(hppr_pkg::CFG_REPLACEMENT_LENGTH, 64'd15);
    write_reg(hppr_pkg::CFG_REPLACEMENT_PATTERN, {$urandom, $urandom});
    end_writes();
    add_method(PFX_HEAD);
    commit_payload(1'b1, 1'b0);
    settle();
    tail_bytes = $urandom;
    write_reg(hppr_pkg::CFG_TARGET_LENGTH, hppr_pkg::CFG_W'(hppr_pkg::MIN_TARGET_LEN));
    write_reg(hppr_pkg::CFG_TARGET_PATTERN,
              {tail_bytes, hppr_pkg::CH_D, hppr_pkg::CH_A, hppr_pkg::CH_E, hppr_pkg::CH_H});
    end_writes();
    for (int k = 0; k < 4; k++) draft.push_back(tail_bytes[8*k +: 8]);
    commit_payload(1'b0, 1'b1);

    // Random phases; each one may leave a payload open across the next settings change
    random_beats = 0;
    first_phase  = 1'b1;
    open_tail    = 1'b0;
    while (random_beats < RANDOM_BEATS) begin
      settle();
      pick_settings(first_phase ? 4'hF : 4'($urandom_range(1, 15)));
      first_phase = 1'b0;
      phase_start = queued_beats;
      if (open_tail) begin
        add_noise($urandom_range(0, 5));
        add_target($urandom_range(0, clamp_len(shadow_tlen, hppr_pkg::MIN_TARGET_LEN,
                                               WINDOW_BYTES)));
        add_noise(1);
        commit_payload(1'($urandom_range(0, 1)), 1'b1);
        open_tail = 1'b0;
      end
      phase_len = $urandom_range(25, 45);
      while (queued_beats - phase_start < phase_len) build_random_payload();
      if ($urandom_range(0, 3) == 0) begin
        add_method(method_pfx_t'($urandom_range(0, 2)));
        add_noise($urandom_range(0, 6));
        commit_payload(1'b1, 1'b0);
        open_tail = 1'b1;
      end
      random_beats += queued_beats - phase_start;
    end
    if (open_tail) begin
      add_noise(1);
      commit_payload(1'b0, 1'b1);
    end

    // Drain everything owed, then a few quiet cycles for stray beats
    settle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hppr_pkg.sv
rtl/hppr_in_if.sv
rtl/hppr_out_if.sv
rtl/hppr_dp.sv
rtl/hppr_ctrl.sv
rtl/http_payload_pattern_replace.sv
bench/testbench.sv
